// ===== hw/rtl/gbc_pkg.sv =====
package gbc_pkg;

    // Default fraction bits of biases, tracking limits and the limit step
    localparam int FRAC_BITS_DEFAULT = 8;

    // Field widths fixed by the stream format
    localparam int RATE_W     = 16;
    localparam int ELAPSED_W  = 16;
    localparam int BIAS_W     = 24;
    localparam int TIMER_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // Stream widths: input carries three rates and the elapsed time,
    // output carries three flags and three biases, padded to whole bytes
    localparam int IN_TDATA_W  = 3 * RATE_W + ELAPSED_W;
    localparam int OUT_FIELD_W = 3 + 3 * BIAS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [7:0]  LIMIT_STEP_RST    = 8'd26;
    localparam logic [14:0] LIMIT_CLAMP_RST   = 15'd800;
    localparam logic [14:0] MOTION_MARGIN_RST = 15'd100;
    localparam logic [23:0] SETTLE_TIME_RST   = 24'd2000000;
    localparam logic [23:0] MAX_TIME_RST      = 24'd15000000;
    localparam logic [15:0] FILTER_KEEP_RST   = 16'd65405;

    // Item kind carried on tuser
    typedef enum logic {
        FUNC_START  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_STEP    = 3'd0,
        CFG_LIMIT_CLAMP   = 3'd1,
        CFG_MOTION_MARGIN = 3'd2,
        CFG_SETTLE_TIME   = 3'd3,
        CFG_MAX_TIME      = 3'd4,
        CFG_FILTER_KEEP   = 3'd5
    } cfg_idx_t;

    // Settings shared by the three axis datapaths
    typedef struct packed {
        logic [7:0]  limit_step;
        logic [14:0] limit_clamp;
        logic [14:0] motion_margin;
        logic [15:0] filter_keep;
    } axis_cfg_t;

endpackage

// ===== hw/rtl/gbc_axis.sv =====
module gbc_axis #(
    parameter int FRAC_BITS = gbc_pkg::FRAC_BITS_DEFAULT
) (
    input  gbc_pkg::axis_cfg_t                     cfg,
    input  logic signed [gbc_pkg::RATE_W-1:0]      rate,
    input  logic signed [gbc_pkg::BIAS_W-1:0]      limit_cur,
    input  logic signed [gbc_pkg::BIAS_W-1:0]      bias_cur,
    output logic signed [gbc_pkg::BIAS_W-1:0]      limit_new,
    output logic signed [gbc_pkg::BIAS_W-1:0]      bias_new,
    output logic                                   motion
);
    import gbc_pkg::*;

    // Working widths
    localparam int SW  = RATE_W + FRAC_BITS;
    localparam int XW  = (SW > BIAS_W) ? SW : BIAS_W;
    localparam int CW  = XW + 2;
    localparam int MW  = CW + 1;
    localparam int DW  = XW + 1;
    localparam int PW  = DW + 18;
    localparam int AW  = ((PW > BIAS_W + 17) ? PW : BIAS_W + 17) + 1;
    localparam int QW  = AW - 16;

    localparam logic signed [CW-1:0] MAX_C  = CW'((1 << (BIAS_W - 1)) - 1);
    localparam logic signed [QW-1:0] MAX_Q  = QW'((1 << (BIAS_W - 1)) - 1);
    localparam logic signed [QW-1:0] MIN_Q  = -QW'(1 << (BIAS_W - 1));
    localparam logic signed [AW-1:0] HALF_A = AW'(1 << 15);
    localparam logic [16:0]          ONE_W  = 17'h10000;

    logic signed [CW-1:0] s_c, lim0, lim1, lim2, lim3, step_c, bound_c, bound_raw;
    logic signed [CW-1:0] abs_s, abs_l, margin_c;
    logic signed [MW-1:0] thresh;
    logic signed [DW-1:0] diff;
    logic [16:0]          wgt;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] acc;
    logic signed [QW-1:0] q;

    // Scale the sample and the settings into the working width
    always_comb begin
        s_c       = {{(CW - RATE_W){rate[RATE_W-1]}}, rate} <<< FRAC_BITS;
        lim0      = {{(CW - BIAS_W){limit_cur[BIAS_W-1]}}, limit_cur};
        step_c    = {{(CW - 8){1'b0}}, cfg.limit_step};
        bound_raw = {{(CW - 15){1'b0}}, cfg.limit_clamp} <<< FRAC_BITS;
        bound_c   = (bound_raw > MAX_C) ? MAX_C : bound_raw;
        margin_c  = {{(CW - 15){1'b0}}, cfg.motion_margin} <<< FRAC_BITS;
    end

    // Step the tracking limit toward the sample, then clamp it
    always_comb begin
        lim1 = (s_c > lim0) ? lim0 + step_c : lim0;
        lim2 = (s_c < lim1) ? lim1 - step_c : lim1;
        if (lim2 > bound_c) begin
            lim3 = bound_c;
        end else if (lim2 < -bound_c) begin
            lim3 = -bound_c;
        end else begin
            lim3 = lim2;
        end
        limit_new = lim3[BIAS_W-1:0];
    end

    // Motion: sample magnitude beyond margin plus limit magnitude
    always_comb begin
        abs_s  = s_c[CW-1] ? -s_c : s_c;
        abs_l  = lim3[CW-1] ? -lim3 : lim3;
        thresh = {margin_c[CW-1], margin_c} + {abs_l[CW-1], abs_l};
        motion = {abs_s[CW-1], abs_s} > thresh;
    end

    // Low-pass filter: bias*2^16 + (S - bias)*(2^16 - keep), round half up
    always_comb begin
        diff = s_c[DW-1:0] - {{(DW - BIAS_W){bias_cur[BIAS_W-1]}}, bias_cur};
        wgt  = ONE_W - {1'b0, cfg.filter_keep};
        prod = {{(PW - DW){diff[DW-1]}}, diff} * $signed({{(PW - 17){1'b0}}, wgt});
        acc  = ({{(AW - BIAS_W){bias_cur[BIAS_W-1]}}, bias_cur} <<< 16)
             + {{(AW - PW){prod[PW-1]}}, prod} + HALF_A;
        q    = acc[AW-1:16];
        if (q > MAX_Q) begin
            bias_new = MAX_Q[BIAS_W-1:0];
        end else if (q < MIN_Q) begin
            bias_new = MIN_Q[BIAS_W-1:0];
        end else begin
            bias_new = q[BIAS_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/gyro_bias_calibrator.sv =====
// Gyro zero-rate bias calibrator. A start beat (tuser 0) copies the current
// biases into the per-axis tracking limits, clears the stillness and total
// timers and begins a calibration; each sample beat (tuser 1) then advances
// both timers by its elapsed microseconds, steps and clamps each axis's
// tracking limit, flags motion (which restarts the stillness timer) or filters
// that axis's bias toward the sample, and ends the run on enough stillness
// (success) or on the time limit (failure, biases cleared). Every input beat
// gives exactly one result beat with the state after it; samples while idle
// only report the biases. The block takes one beat per clock cycle while the
// result stream does not stall: an input register, then per-axis limit, motion
// and filter logic (one 25x17 multiplier per axis at the default FRAC_BITS)
// into the result register. Configuration is written through cfg_we, cfg_index
// and cfg_wdata and should change only while no beats are in flight.
module gyro_bias_calibrator #(
    parameter int FRAC_BITS = gbc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: rate_x[15:0], rate_y[31:16], rate_z[47:32], elapsed_us[63:48]
    input  logic [gbc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // tuser: func (0 start, 1 sample)
    input  logic                                s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: busy_res[0], done_res[1], failed[2], bias_x[26:3],
    //        bias_y[50:27], bias_z[74:51], zero pad[79:75]
    output logic [gbc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import gbc_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

    // Configuration registers
    logic [7:0]         limit_step_reg;
    logic [14:0]        limit_clamp_reg;
    logic [14:0]        motion_margin_reg;
    logic [TIMER_W-1:0] settle_time_reg;
    logic [TIMER_W-1:0] max_time_reg;
    logic [15:0]        filter_keep_reg;

    // Input register
    logic                  in_vld_reg;
    func_t                 in_func_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;

    // Calibration state
    logic signed [BIAS_W-1:0] bias_reg  [3];
    logic signed [BIAS_W-1:0] limit_reg [3];
    logic [TIMER_W-1:0]       still_reg, total_reg;
    logic                     running_reg;

    logic signed [BIAS_W-1:0] bias_next  [3];
    logic signed [BIAS_W-1:0] limit_next [3];
    logic [TIMER_W-1:0]       still_next, total_next;
    logic                     running_next;

    // Result register
    logic                   out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // Axis datapath signals
    axis_cfg_t                axis_cfg;
    logic signed [BIAS_W-1:0] axis_limit [3];
    logic signed [BIAS_W-1:0] axis_bias  [3];
    logic [2:0]               axis_motion;

    logic                 advance;
    logic [ELAPSED_W-1:0] elapsed;
    logic [TIMER_W:0]     still_sum, total_sum;
    logic [TIMER_W-1:0]   still_add, total_add;
    logic                 done, failed;

    // Handshake: the result register frees the input register
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_step_reg    <= LIMIT_STEP_RST;
            limit_clamp_reg   <= LIMIT_CLAMP_RST;
            motion_margin_reg <= MOTION_MARGIN_RST;
            settle_time_reg   <= SETTLE_TIME_RST;
            max_time_reg      <= MAX_TIME_RST;
            filter_keep_reg   <= FILTER_KEEP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LIMIT_STEP:    limit_step_reg    <= cfg_wdata[7:0];
                CFG_LIMIT_CLAMP:   limit_clamp_reg   <= cfg_wdata[14:0];
                CFG_MOTION_MARGIN: motion_margin_reg <= cfg_wdata[14:0];
                CFG_SETTLE_TIME:   settle_time_reg   <= cfg_wdata[TIMER_W-1:0];
                CFG_MAX_TIME:      max_time_reg      <= cfg_wdata[TIMER_W-1:0];
                CFG_FILTER_KEEP:   filter_keep_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Capture an input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_func_reg <= func_t'(s_tuser);
            in_data_reg <= s_tdata;
        end
    end

    // Per-axis tracking limit, motion test and bias filter
    assign axis_cfg.limit_step    = limit_step_reg;
    assign axis_cfg.limit_clamp   = limit_clamp_reg;
    assign axis_cfg.motion_margin = motion_margin_reg;
    assign axis_cfg.filter_keep   = filter_keep_reg;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        gbc_axis #(
            .FRAC_BITS (FRAC_BITS)
        ) u_axis (
            .cfg       (axis_cfg),
            .rate      (in_data_reg[a*RATE_W +: RATE_W]),
            .limit_cur (limit_reg[a]),
            .bias_cur  (bias_reg[a]),
            .limit_new (axis_limit[a]),
            .bias_new  (axis_bias[a]),
            .motion    (axis_motion[a])
        );
    end

    // Advance the timers, saturating at full scale
    assign elapsed   = in_data_reg[3*RATE_W +: ELAPSED_W];
    assign still_sum = {1'b0, still_reg} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, elapsed};
    assign total_sum = {1'b0, total_reg} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, elapsed};
    assign still_add = still_sum[TIMER_W] ? '1 : still_sum[TIMER_W-1:0];
    assign total_add = total_sum[TIMER_W] ? '1 : total_sum[TIMER_W-1:0];

    // Next state and result for the beat in the input register
    always_comb begin
        bias_next    = bias_reg;
        limit_next   = limit_reg;
        still_next   = still_reg;
        total_next   = total_reg;
        running_next = running_reg;
        done         = 1'b0;
        failed       = 1'b0;
        if (in_func_reg == FUNC_START) begin
            limit_next   = bias_reg;
            still_next   = '0;
            total_next   = '0;
            running_next = 1'b1;
        end else if (running_reg) begin
            limit_next = axis_limit;
            for (int a = 0; a < 3; a++) begin
                if (!axis_motion[a]) begin
                    bias_next[a] = axis_bias[a];
                end
            end
            still_next = (|axis_motion) ? '0 : still_add;
            total_next = total_add;
            if (still_next >= settle_time_reg) begin
                done         = 1'b1;
                running_next = 1'b0;
            end else if (total_next >= max_time_reg) begin
                done         = 1'b1;
                failed       = 1'b1;
                running_next = 1'b0;
                for (int a = 0; a < 3; a++) begin
                    bias_next[a] = '0;
                end
            end
        end
        out_data_next = {{PAD_W{1'b0}}, bias_next[2], bias_next[1], bias_next[0],
                         failed, done, running_next};
    end

    // Update the state on each processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                bias_reg[a]  <= '0;
                limit_reg[a] <= '0;
            end
            still_reg   <= '0;
            total_reg   <= '0;
            running_reg <= 1'b0;
        end else if (advance) begin
            bias_reg    <= bias_next;
            limit_reg   <= limit_next;
            still_reg   <= still_next;
            total_reg   <= total_next;
            running_reg <= running_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // A finished run is never reported as still busy
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tdata[0])
        else $error("done beat reports busy");

    // Failure only on a finishing beat, with the biases cleared
    a_fail_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1] && (m_tdata[OUT_FIELD_W-1:3] == '0))
        else $error("failed beat without done or with biases left");

    // The stillness timer never runs ahead of the total timer
    a_timer_order: assert property (@(posedge aclk) disable iff (!aresetn)
        still_reg <= total_reg)
        else $error("stillness timer exceeds total timer");

    // A start beat leaves the block running with cleared timers
    a_start_run: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_func_reg == FUNC_START)
        |=> running_reg && (still_reg == '0) && (total_reg == '0))
        else $error("start beat did not begin a run");

endmodule
